// File: rtl/rsrb_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer package
// Types and codes shared by the sequence reorder buffer modules.
// ----------------------------------------------------------------------------
package rsrb_pkg;

    localparam int SEQ_BITS    = 32;
    localparam int HANDLE_BITS = 12;
    localparam int KIND_BITS   = 8;
    localparam int DISP_BITS   = 3;

    localparam logic [DISP_BITS-1:0] DISP_DELIVERED = 3'd0;
    localparam logic [DISP_BITS-1:0] DISP_ACK_FREED = 3'd1;
    localparam logic [DISP_BITS-1:0] DISP_DUPLICATE = 3'd2;
    localparam logic [DISP_BITS-1:0] DISP_BUFFERED  = 3'd3;
    localparam logic [DISP_BITS-1:0] DISP_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic                   reliable;
        logic                   is_ack;
        logic [SEQ_BITS-1:0]    seq_number;
        logic [KIND_BITS-1:0]   seg_kind;
        logic [HANDLE_BITS-1:0] handle;
    } in_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] out_handle;
        logic [KIND_BITS-1:0]   out_kind;
        logic [DISP_BITS-1:0]   disposition;
        logic                   last;
    } out_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [KIND_BITS-1:0]   kind;
    } slot_t;

endpackage

// File: rtl/rsrb_slot_ram.sv
// ----------------------------------------------------------------------------
// Reorder buffer slot memory
// One write port and one registered read port holding buffered segments.
// ----------------------------------------------------------------------------
module rsrb_slot_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  rsrb_pkg::slot_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output rsrb_pkg::slot_t rd_data
);

    rsrb_pkg::slot_t slot_mem [DEPTH];
    rsrb_pkg::slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rsrb_ctrl.sv
// ----------------------------------------------------------------------------
// Reorder buffer control
// Classifies each segment, tracks the window state and drains buffered
// successors from the slot memory into the output register.
// ----------------------------------------------------------------------------
module rsrb_ctrl #(
    parameter int WINDOW = 32,
    parameter int IW     = 5
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rsrb_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rsrb_pkg::out_t  m_data,
    output logic            mem_wr_en,
    output logic [IW-1:0]   mem_wr_addr,
    output rsrb_pkg::slot_t mem_wr_data,
    output logic            mem_rd_en,
    output logic [IW-1:0]   mem_rd_addr,
    input  rsrb_pkg::slot_t mem_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [rsrb_pkg::SEQ_BITS-1:0]   last_seq_reg, last_seq_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [WINDOW-1:0]               valid_reg, valid_next;
    logic                            m_valid_reg, m_valid_next;
    rsrb_pkg::out_t                  m_data_reg, m_data_next;

    logic                            out_free;
    logic                            accept;
    logic [rsrb_pkg::SEQ_BITS-1:0]   d_seq;
    logic [rsrb_pkg::SEQ_BITS-1:0]   seq_gap;
    logic [IW-1:0]                   d_idx;
    logic [IW-1:0]                   p_idx;
    logic                            p_valid;
    logic [IW+1:0]                   bsum;
    logic [IW-1:0]                   buf_idx;
    logic                            buf_wr;
    logic                            drain_emit;

    function automatic logic [IW-1:0] adv_idx(input logic [IW-1:0] i,
                                              input logic [rsrb_pkg::SEQ_BITS-1:0] s);
        logic [IW-1:0] r;
        if (s == '0) begin
            r = '0;
        end else if (i == IW'(WINDOW - 1)) begin
            r = '0;
        end else begin
            r = i + IW'(1);
        end
        return r;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign d_seq   = last_seq_reg + 32'd1;
    assign d_idx   = adv_idx(idx_reg, d_seq);
    assign p_idx   = adv_idx(d_idx, d_seq + 32'd1);
    assign p_valid = valid_reg[p_idx] && (p_idx != d_idx);

    assign seq_gap = s_data.seq_number - last_seq_reg;
    assign bsum    = {2'b00, idx_reg} + (IW+2)'(seq_gap[IW:0]);
    assign buf_idx = (bsum >= (IW+2)'(WINDOW)) ? IW'(bsum - (IW+2)'(WINDOW)) : IW'(bsum);

    always_comb begin
        state_next    = state_reg;
        last_seq_next = last_seq_reg;
        idx_next      = idx_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        buf_wr        = 1'b0;
        drain_emit    = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = p_idx;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next           = 1'b1;
                    m_data_next.out_handle = s_data.handle;
                    m_data_next.out_kind   = s_data.seg_kind;
                    m_data_next.last       = 1'b1;
                    if (!s_data.reliable) begin
                        m_data_next.disposition = s_data.is_ack ? rsrb_pkg::DISP_ACK_FREED
                                                                : rsrb_pkg::DISP_DELIVERED;
                    end else if (s_data.seq_number == d_seq) begin
                        m_data_next.disposition = rsrb_pkg::DISP_DELIVERED;
                        m_data_next.last        = !p_valid;
                        last_seq_next           = d_seq;
                        idx_next                = d_idx;
                        if (p_valid) begin
                            mem_rd_en  = 1'b1;
                            state_next = ST_DRAIN;
                        end
                    end else if (s_data.seq_number > last_seq_reg) begin
                        if (seq_gap > 32'(WINDOW)) begin
                            m_data_next.disposition = rsrb_pkg::DISP_OVERFLOW;
                        end else if (valid_reg[buf_idx]) begin
                            m_data_next.disposition = rsrb_pkg::DISP_DUPLICATE;
                        end else begin
                            m_data_next.disposition = rsrb_pkg::DISP_BUFFERED;
                            buf_wr                  = 1'b1;
                        end
                    end else begin
                        m_data_next.disposition = rsrb_pkg::DISP_DUPLICATE;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    drain_emit              = 1'b1;
                    m_valid_next            = 1'b1;
                    m_data_next.out_handle  = mem_rd_data.handle;
                    m_data_next.out_kind    = mem_rd_data.kind;
                    m_data_next.disposition = rsrb_pkg::DISP_DELIVERED;
                    m_data_next.last        = !p_valid;
                    last_seq_next           = d_seq;
                    idx_next                = d_idx;
                    if (p_valid) begin
                        mem_rd_en = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (buf_wr) begin
            valid_next[buf_idx] = 1'b1;
        end
        if (drain_emit) begin
            valid_next[d_idx] = 1'b0;
        end
    end

    assign mem_wr_en          = buf_wr;
    assign mem_wr_addr        = buf_idx;
    assign mem_wr_data.handle = s_data.handle;
    assign mem_wr_data.kind   = s_data.seg_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_seq_reg <= '0;
            idx_reg      <= '0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_seq_reg <= last_seq_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // While draining, the output register always holds a non-final result.
    a_drain_holds_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (m_valid_reg && !m_data_reg.last))
        else $error("drain state without an open result sequence");

    // A buffered segment marks its slot as occupied.
    a_buffer_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_wr |=> valid_reg[$past(buf_idx)])
        else $error("buffered slot not marked valid");

    // Once a non-final result is taken, the next one follows without a gap.
    a_no_gap_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> m_valid)
        else $error("gap inside a drained result sequence");

    // A drained slot is released.
    a_drain_clears_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_emit |=> !valid_reg[$past(d_idx)])
        else $error("drained slot still valid");
`endif

endmodule

// File: rtl/reliable_sequence_reorder_buffer_top.sv
// The first result of a segment is in the output register in the cycle after acceptance.
// Throughput: one segment per cycle while the output is taken; each drained successor
// then follows from the single read port of the slot memory while s_ready is held low.
// A segment that releases buffered successors keeps s_ready low until the last one is loaded.
// Reset: synchronous active-low aresetn clears the last delivered sequence number and all slot
// valid bits; slot contents are not cleared.
// ----------------------------------------------------------------------------
// Reliable sequence reorder buffer
// Delivers reliable segments in sequence order and passes unreliable ones through.
// ----------------------------------------------------------------------------
module reliable_sequence_reorder_buffer_top #(
    parameter int WINDOW = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rsrb_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rsrb_pkg::out_t m_data
);

    localparam int IW = $clog2(WINDOW);

    logic            mem_wr_en;
    logic [IW-1:0]   mem_wr_addr;
    rsrb_pkg::slot_t mem_wr_data;
    logic            mem_rd_en;
    logic [IW-1:0]   mem_rd_addr;
    rsrb_pkg::slot_t mem_rd_data;

    rsrb_ctrl #(
        .WINDOW (WINDOW),
        .IW     (IW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rsrb_slot_ram #(
        .DEPTH (WINDOW),
        .AW    (IW)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
